@@ sv/mexp_pkg.sv @@
// Package for the right-to-left modular exponentiation core.
// Holds field widths, the microcode word type and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int BASE_W      = 64;
  localparam int EXP_FIELD_W = 64;
  localparam int MOD_FIELD_W = 32;
  localparam int RES_W       = 32;
  localparam int CNT_W       = $clog2(BASE_W + 1);
  localparam int PC_W        = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LD_RED,
    OP_STEP,
    OP_ST_PW_INIT,
    OP_LD_MUL,
    OP_ST_ACC,
    OP_LD_SQ,
    OP_ST_PW_SHIFT,
    OP_EMIT,
    OP_SET_BAD
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IN_IDLE,
    C_MOD_ZERO,
    C_CNT_BUSY,
    C_EXP_ZERO,
    C_BIT_CLR,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucw_t;

  // Microcode step addresses.
  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_CHKMOD  = 4'd1;
  localparam pc_t PC_REDLD   = 4'd2;
  localparam pc_t PC_REDSTEP = 4'd3;
  localparam pc_t PC_PWINIT  = 4'd4;
  localparam pc_t PC_EXPTEST = 4'd5;
  localparam pc_t PC_BITTEST = 4'd6;
  localparam pc_t PC_MULLD   = 4'd7;
  localparam pc_t PC_MULSTEP = 4'd8;
  localparam pc_t PC_ACCST   = 4'd9;
  localparam pc_t PC_SQLD    = 4'd10;
  localparam pc_t PC_SQSTEP  = 4'd11;
  localparam pc_t PC_PWST    = 4'd12;
  localparam pc_t PC_EMIT    = 4'd13;
  localparam pc_t PC_RET     = 4'd14;
  localparam pc_t PC_BAD     = 4'd15;

  // Microcode ROM. A word jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  function automatic ucw_t ucode(pc_t pc);
    ucw_t w;
    unique case (pc)
      PC_IDLE:    w = '{op: OP_CAPTURE,     cond: C_IN_IDLE,  target: PC_IDLE};
      PC_CHKMOD:  w = '{op: OP_NOP,         cond: C_MOD_ZERO, target: PC_BAD};
      PC_REDLD:   w = '{op: OP_LD_RED,      cond: C_NEXT,     target: PC_IDLE};
      PC_REDSTEP: w = '{op: OP_STEP,        cond: C_CNT_BUSY, target: PC_REDSTEP};
      PC_PWINIT:  w = '{op: OP_ST_PW_INIT,  cond: C_NEXT,     target: PC_IDLE};
      PC_EXPTEST: w = '{op: OP_NOP,         cond: C_EXP_ZERO, target: PC_EMIT};
      PC_BITTEST: w = '{op: OP_NOP,         cond: C_BIT_CLR,  target: PC_SQLD};
      PC_MULLD:   w = '{op: OP_LD_MUL,      cond: C_NEXT,     target: PC_IDLE};
      PC_MULSTEP: w = '{op: OP_STEP,        cond: C_CNT_BUSY, target: PC_MULSTEP};
      PC_ACCST:   w = '{op: OP_ST_ACC,      cond: C_NEXT,     target: PC_IDLE};
      PC_SQLD:    w = '{op: OP_LD_SQ,       cond: C_NEXT,     target: PC_IDLE};
      PC_SQSTEP:  w = '{op: OP_STEP,        cond: C_CNT_BUSY, target: PC_SQSTEP};
      PC_PWST:    w = '{op: OP_ST_PW_SHIFT, cond: C_ALWAYS,   target: PC_EXPTEST};
      PC_EMIT:    w = '{op: OP_EMIT,        cond: C_OUT_FULL, target: PC_EMIT};
      PC_RET:     w = '{op: OP_NOP,         cond: C_ALWAYS,   target: PC_IDLE};
      PC_BAD:     w = '{op: OP_SET_BAD,     cond: C_ALWAYS,   target: PC_EMIT};
    endcase
    return w;
  endfunction

endpackage

@@ sv/mexp_if.sv @@
// Valid/ready channel interfaces for the modular exponentiation core.
// Depends on mexp_pkg for the field widths.
`timescale 1ns / 1ps

interface mexp_in_if;
  import mexp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BASE_W-1:0]      base;
  logic [EXP_FIELD_W-1:0] exponent;
  logic [MOD_FIELD_W-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] power_mod;
  logic             bad_modulus;

  modport source (output valid, output power_mod, output bad_modulus, input ready);
  modport sink   (input valid, input power_mod, input bad_modulus, output ready);
endinterface

@@ sv/mexp_modstep.sv @@
// One step of interleaved modular multiplication: r' = (2r + bit*a) mod m.
// Standalone combinational logic; no package needed.
`timescale 1ns / 1ps

module mexp_modstep #(
  parameter int MOD_WIDTH = 32
) (
  input  logic [MOD_WIDTH-1:0] r_i,
  input  logic [MOD_WIDTH-1:0] a_i,
  input  logic [MOD_WIDTH-1:0] m_i,
  input  logic                 bit_i,
  output logic [MOD_WIDTH-1:0] r_o
);

  localparam int SW = MOD_WIDTH + 2;

  logic [SW-1:0] sum;
  logic [SW-1:0] m1;
  logic [SW-1:0] m2;

  // The sum stays below three times the modulus, so one of three candidates fits.
  assign sum = SW'({r_i, 1'b0}) + (bit_i ? SW'(a_i) : SW'(0));
  assign m1  = SW'(m_i);
  assign m2  = SW'({m_i, 1'b0});

  always_comb begin
    priority if (sum >= m2) begin
      r_o = MOD_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      r_o = MOD_WIDTH'(sum - m1);
    end else begin
      r_o = MOD_WIDTH'(sum);
    end
  end

endmodule

@@ sv/modexp_right_to_left_core.sv @@
// Top level of the right-to-left modular exponentiation core.
// Depends on mexp_pkg, mexp_in_if / mexp_out_if and mexp_modstep.
`timescale 1ns / 1ps

// The input channel carries one word of base, exponent and modulus; the result
// channel carries one word of power_mod and bad_modulus per input word. Both
// use valid/ready and a word moves on a rising edge with both high.
//
// A small microcode program in a ROM sequences a plain datapath built around a
// single modular step unit that does one bit of shift-and-add multiplication
// with reduction each cycle. The base is first reduced in 64 steps, then each
// exponent bit costs a squaring of the current power, plus a multiplication
// into the running result when the bit is set. Only bits up to the highest
// set exponent bit are visited. A zero modulus skips the computation and
// gives an error result with bad_modulus set.
//
// One word is processed at a time. The result sits in an output register, so
// the core takes the next input word while a finished result still waits; if
// the receiver stalls and a second result is ready, the sequencer holds on
// its emit step until the register frees up. Synchronous reset returns the
// sequencer to its idle step and empties the output register.

module modexp_right_to_left_core #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  mexp_in_if.sink     in_chan,
  mexp_out_if.source  out_chan
);
  import mexp_pkg::*;

  // Sequencer.
  pc_t  pc_r, pc_nxt;
  ucw_t uc;
  logic jump;

  // Datapath registers.
  logic [BASE_W-1:0]    mb_r, mb_nxt;     // multiplier bits, consumed from the top
  logic [MOD_WIDTH-1:0] r_r, r_nxt;       // partial product
  logic [MOD_WIDTH-1:0] a_r, a_nxt;       // multiplicand
  logic [MOD_WIDTH-1:0] mod_r, mod_nxt;
  logic [MOD_WIDTH-1:0] pw_r, pw_nxt;     // current power of the base
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;   // running result
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 bad_r, bad_nxt;

  // Output register.
  logic                 ov_r, ov_nxt;
  logic [RES_W-1:0]     opm_r, opm_nxt;
  logic                 obad_r, obad_nxt;

  logic [MOD_WIDTH-1:0] step_res;
  logic                 out_full;

  mexp_modstep #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_step (
    .r_i   (r_r),
    .a_i   (a_r),
    .m_i   (mod_r),
    .bit_i (mb_r[BASE_W-1]),
    .r_o   (step_res)
  );

  assign uc       = ucode(pc_r);
  assign out_full = ov_r && !out_chan.ready;

  assign in_chan.ready         = (uc.op == OP_CAPTURE);
  assign out_chan.valid        = ov_r;
  assign out_chan.power_mod    = opm_r;
  assign out_chan.bad_modulus  = obad_r;

  // Next step: jump when the condition holds, else fall through.
  always_comb begin
    unique case (uc.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_IN_IDLE:  jump = !in_chan.valid;
      C_MOD_ZERO: jump = (mod_r == '0);
      C_CNT_BUSY: jump = (cnt_r != CNT_W'(1));
      C_EXP_ZERO: jump = (exp_r == '0);
      C_BIT_CLR:  jump = !exp_r[0];
      C_OUT_FULL: jump = out_full;
    endcase
    pc_nxt = jump ? uc.target : pc_r + 1'b1;
  end

  // Datapath control driven by the current control word.
  always_comb begin
    mb_nxt   = mb_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    mod_nxt  = mod_r;
    pw_nxt   = pw_r;
    acc_nxt  = acc_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    bad_nxt  = bad_r;
    ov_nxt   = ov_r && !out_chan.ready;
    opm_nxt  = opm_r;
    obad_nxt = obad_r;

    unique case (uc.op)
      OP_NOP: begin
      end
      OP_CAPTURE: begin
        if (in_chan.valid) begin
          mb_nxt  = in_chan.base;
          exp_nxt = in_chan.exponent[EXP_WIDTH-1:0];
          mod_nxt = in_chan.modulus[MOD_WIDTH-1:0];
          bad_nxt = 1'b0;
        end
      end
      OP_LD_RED: begin
        // Reducing the base: each step shifts in one base bit with an addend of one.
        r_nxt   = '0;
        a_nxt   = MOD_WIDTH'(1);
        cnt_nxt = CNT_W'(BASE_W);
      end
      OP_STEP: begin
        r_nxt   = step_res;
        mb_nxt  = mb_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_ST_PW_INIT: begin
        pw_nxt  = r_r;
        acc_nxt = MOD_WIDTH'(1);
      end
      OP_LD_MUL: begin
        r_nxt   = '0;
        a_nxt   = acc_r;
        mb_nxt  = {pw_r, {(BASE_W - MOD_WIDTH){1'b0}}};
        cnt_nxt = CNT_W'(MOD_WIDTH);
      end
      OP_ST_ACC: begin
        acc_nxt = r_r;
      end
      OP_LD_SQ: begin
        r_nxt   = '0;
        a_nxt   = pw_r;
        mb_nxt  = {pw_r, {(BASE_W - MOD_WIDTH){1'b0}}};
        cnt_nxt = CNT_W'(MOD_WIDTH);
      end
      OP_ST_PW_SHIFT: begin
        pw_nxt  = r_r;
        exp_nxt = exp_r >> 1;
      end
      OP_EMIT: begin
        if (!out_full) begin
          ov_nxt   = 1'b1;
          opm_nxt  = RES_W'(acc_r);
          obad_nxt = bad_r;
        end
      end
      OP_SET_BAD: begin
        acc_nxt = '0;
        bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
      ov_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      ov_r <= ov_nxt;
    end
    mb_r   <= mb_nxt;
    r_r    <= r_nxt;
    a_r    <= a_nxt;
    mod_r  <= mod_nxt;
    pw_r   <= pw_nxt;
    acc_r  <= acc_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    bad_r  <= bad_nxt;
    opm_r  <= opm_nxt;
    obad_r <= obad_nxt;
  end

endmodule
